FILE: hdl/elbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package elbc_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int DLY_W     = 48;
   localparam int FRAC_W    = 24;
   localparam int COEF_W    = 28;
   localparam int COEF_FRAC = 22;
   localparam int NUM_SECT  = 4;
   localparam int NUM_DLY   = 2 * NUM_SECT;
   localparam int DLY_IDX_W = $clog2(NUM_DLY);
   localparam int SECT_W    = $clog2(NUM_SECT);
   localparam int NUM_COEF  = 3 * NUM_SECT + 1;
   localparam int COEF_IDX_W = $clog2(NUM_COEF);
   localparam int PHI_W     = (DLY_W - FRAC_W) + COEF_W;
   localparam int PLO_W     = FRAC_W + 1 + COEF_W;
   localparam int PROD_W    = DLY_W + COEF_W;
   localparam int PRODR_W   = PROD_W - COEF_FRAC;
   localparam int ACC_W     = 56;
   localparam int NUM_STEPS = 25;
   localparam int STEP_W    = $clog2(NUM_STEPS);

   localparam logic [COEF_IDX_W-1:0] GAIN_IDX = COEF_IDX_W'(NUM_COEF - 1);

   typedef enum logic [1:0] {
      NX_STEP,
      NX_WAIT_IN,
      NX_WAIT_OUT
   } nx_type;

   typedef enum logic {
      SRC_DLY,
      SRC_ACC
   } msrc_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_ADD_P,
      ACC_SAT_ADD_P,
      ACC_SATW_ADD_P,
      ACC_ADD_D
   } acc_op_type;

   typedef struct packed {
      nx_type                  nx;
      logic                    mul_en;
      msrc_type                msrc;
      logic [DLY_IDX_W-1:0]    mul_idx;
      logic [COEF_IDX_W-1:0]   coef_idx;
      acc_op_type              acc_op;
      logic [DLY_IDX_W-1:0]    add_idx;
      logic                    sh_en;
      logic [SECT_W-1:0]       sh_sec;
   } ctrl_type;

   function automatic logic signed [COEF_W-1:0] coef_rom(input logic [COEF_IDX_W-1:0] idx);
      logic signed [COEF_W-1:0] c;
      unique case (idx)
         4'd0:    c =  28'sd6770281;
         4'd1:    c = -28'sd3788082;
         4'd2:    c = -28'sd4132511;
         4'd3:    c =  28'sd7041906;
         4'd4:    c = -28'sd3480768;
         4'd5:    c = -28'sd1542724;
         4'd6:    c =  28'sd7298937;
         4'd7:    c = -28'sd3246092;
         4'd8:    c =  28'sd5679806;
         4'd9:    c =  28'sd6687678;
         4'd10:   c = -28'sd4065192;
         4'd11:   c = -28'sd4913130;
         4'd12:   c =  28'sd117378943;
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic signed [DLY_W-1:0] sat_dly(input logic signed [ACC_W-1:0] v);
      logic signed [DLY_W-1:0] r;
      if (v[ACC_W-1:DLY_W-1] == {(ACC_W-DLY_W+1){v[ACC_W-1]}}) begin
         r = v[DLY_W-1:0];
      end else begin
         r = {v[ACC_W-1], {(DLY_W-1){~v[ACC_W-1]}}};
      end
      return r;
   endfunction

   function automatic ctrl_type cw(input nx_type nx, input logic mul_en, input msrc_type msrc,
                                   input int mul_idx, input int coef_idx,
                                   input acc_op_type acc_op, input int add_idx,
                                   input logic sh_en, input int sh_sec);
      ctrl_type w;
      w.nx       = nx;
      w.mul_en   = mul_en;
      w.msrc     = msrc;
      w.mul_idx  = DLY_IDX_W'(mul_idx);
      w.coef_idx = COEF_IDX_W'(coef_idx);
      w.acc_op   = acc_op;
      w.add_idx  = DLY_IDX_W'(add_idx);
      w.sh_en    = sh_en;
      w.sh_sec   = SECT_W'(sh_sec);
      return w;
   endfunction

   function automatic ctrl_type ucode_word(input logic [STEP_W-1:0] step);
      ctrl_type w;
      unique case (step)
         5'd0:    w = cw(NX_WAIT_IN,  1'b0, SRC_DLY, 0, 0,  ACC_HOLD,       0, 1'b0, 0);
         5'd1:    w = cw(NX_STEP,     1'b1, SRC_DLY, 0, 0,  ACC_HOLD,       0, 1'b0, 0);
         5'd2:    w = cw(NX_STEP,     1'b1, SRC_DLY, 1, 1,  ACC_HOLD,       0, 1'b0, 0);
         5'd3:    w = cw(NX_STEP,     1'b1, SRC_DLY, 0, 2,  ACC_SAT_ADD_P,  0, 1'b0, 0);
         5'd4:    w = cw(NX_STEP,     1'b0, SRC_DLY, 0, 0,  ACC_ADD_P,      0, 1'b0, 0);
         5'd5:    w = cw(NX_STEP,     1'b0, SRC_DLY, 0, 0,  ACC_SATW_ADD_P, 0, 1'b0, 0);
         5'd6:    w = cw(NX_STEP,     1'b1, SRC_DLY, 2, 3,  ACC_ADD_D,      1, 1'b0, 0);
         5'd7:    w = cw(NX_STEP,     1'b1, SRC_DLY, 3, 4,  ACC_HOLD,       0, 1'b0, 0);
         5'd8:    w = cw(NX_STEP,     1'b1, SRC_DLY, 2, 5,  ACC_SAT_ADD_P,  0, 1'b1, 0);
         5'd9:    w = cw(NX_STEP,     1'b0, SRC_DLY, 0, 0,  ACC_ADD_P,      0, 1'b0, 0);
         5'd10:   w = cw(NX_STEP,     1'b0, SRC_DLY, 0, 0,  ACC_SATW_ADD_P, 0, 1'b0, 0);
         5'd11:   w = cw(NX_STEP,     1'b1, SRC_DLY, 4, 6,  ACC_ADD_D,      3, 1'b0, 0);
         5'd12:   w = cw(NX_STEP,     1'b1, SRC_DLY, 5, 7,  ACC_HOLD,       0, 1'b0, 0);
         5'd13:   w = cw(NX_STEP,     1'b1, SRC_DLY, 4, 8,  ACC_SAT_ADD_P,  0, 1'b1, 1);
         5'd14:   w = cw(NX_STEP,     1'b0, SRC_DLY, 0, 0,  ACC_ADD_P,      0, 1'b0, 0);
         5'd15:   w = cw(NX_STEP,     1'b0, SRC_DLY, 0, 0,  ACC_SATW_ADD_P, 0, 1'b0, 0);
         5'd16:   w = cw(NX_STEP,     1'b1, SRC_DLY, 6, 9,  ACC_ADD_D,      5, 1'b0, 0);
         5'd17:   w = cw(NX_STEP,     1'b1, SRC_DLY, 7, 10, ACC_HOLD,       0, 1'b0, 0);
         5'd18:   w = cw(NX_STEP,     1'b1, SRC_DLY, 6, 11, ACC_SAT_ADD_P,  0, 1'b1, 2);
         5'd19:   w = cw(NX_STEP,     1'b0, SRC_DLY, 0, 0,  ACC_ADD_P,      0, 1'b0, 0);
         5'd20:   w = cw(NX_STEP,     1'b0, SRC_DLY, 0, 0,  ACC_SATW_ADD_P, 0, 1'b0, 0);
         5'd21:   w = cw(NX_STEP,     1'b0, SRC_DLY, 0, 0,  ACC_ADD_D,      7, 1'b0, 0);
         5'd22:   w = cw(NX_STEP,     1'b1, SRC_ACC, 0, 12, ACC_HOLD,       0, 1'b1, 3);
         5'd23:   w = cw(NX_STEP,     1'b0, SRC_DLY, 0, 0,  ACC_HOLD,       0, 1'b0, 0);
         5'd24:   w = cw(NX_WAIT_OUT, 1'b0, SRC_DLY, 0, 0,  ACC_HOLD,       0, 1'b0, 0);
         default: w = cw(NX_WAIT_OUT, 1'b0, SRC_DLY, 0, 0,  ACC_HOLD,       0, 1'b0, 0);
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/elbc_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

module elbc_sequencer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic              out_busy,
   output elbc_pkg::ctrl_type     ctrl,
   output logic                   in_ready,
   output logic                   out_load
);
   import elbc_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      ctrl     = ucode_word(step_ff);
      in_ready = 1'b0;
      out_load = 1'b0;
      step_in  = step_ff;
      unique case (ctrl.nx)
         NX_STEP: begin
            step_in = step_ff + STEP_W'(1);
         end
         NX_WAIT_IN: begin
            in_ready = 1'b1;
            if (in_valid) begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         NX_WAIT_OUT: begin
            if (!out_busy) begin
               out_load = 1'b1;
               step_in  = '0;
            end
         end
         default: begin
            step_in = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/elbc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module elbc_datapath #(
   parameter int SAMPLE_WIDTH = elbc_pkg::SAMPLE_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire elbc_pkg::ctrl_type             ctrl,
   input  wire logic                           load,
   input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
   output logic signed [SAMPLE_WIDTH-1:0]      sample_out
);
   import elbc_pkg::*;

   localparam int IN_SHIFT  = 25 - SAMPLE_WIDTH;
   localparam int OUT_SHIFT = 65 - SAMPLE_WIDTH;
   localparam logic signed [PROD_W-1:0] COEF_RND = PROD_W'(1) << (COEF_FRAC - 1);
   localparam logic signed [PROD_W-1:0] GAIN_RND = PROD_W'(1) << (OUT_SHIFT - 1);

   logic signed [DLY_W-1:0]   dly_ff [NUM_DLY];
   logic signed [DLY_W-1:0]   w_ff;
   logic signed [DLY_W-1:0]   w_in;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [PHI_W-1:0]   p_hi_ff;
   logic signed [PHI_W-1:0]   p_hi_in;
   logic signed [PLO_W-1:0]   p_lo_ff;
   logic signed [PLO_W-1:0]   p_lo_in;
   logic                      pgain_ff;
   logic                      pvld_ff;
   logic signed [PRODR_W-1:0] prod_ff;
   logic signed [PRODR_W-1:0] prod_in;

   logic signed [ACC_W-1:0]          x_load;
   logic signed [DLY_W-1:0]          acc_sat;
   logic signed [ACC_W-1:0]          acc_sat_ext;
   logic signed [ACC_W-1:0]          prod_ext;
   logic signed [ACC_W-1:0]          dly_ext;
   logic signed [DLY_W-1:0]          mop;
   logic signed [DLY_W-FRAC_W-1:0]   m_hi;
   logic signed [FRAC_W:0]           m_lo;
   logic signed [COEF_W-1:0]         coef;
   logic signed [PROD_W-1:0]         full;
   logic signed [PROD_W-1:0]         rnd_coef;
   logic signed [PROD_W-1:0]         rnd_gain;

   always_comb begin
      x_load = {{(ACC_W-SAMPLE_WIDTH){sample_in[SAMPLE_WIDTH-1]}}, sample_in} <<< IN_SHIFT;
      acc_sat     = sat_dly(acc_ff);
      acc_sat_ext = {{(ACC_W-DLY_W){acc_sat[DLY_W-1]}}, acc_sat};
      prod_ext    = {{(ACC_W-PRODR_W){prod_ff[PRODR_W-1]}}, prod_ff};
      dly_ext     = {{(ACC_W-DLY_W){dly_ff[ctrl.add_idx][DLY_W-1]}}, dly_ff[ctrl.add_idx]};

      mop     = (ctrl.msrc == SRC_ACC) ? acc_sat : dly_ff[ctrl.mul_idx];
      m_hi    = mop[DLY_W-1:FRAC_W];
      m_lo    = {1'b0, mop[FRAC_W-1:0]};
      coef    = coef_rom(ctrl.coef_idx);
      p_hi_in = m_hi * coef;
      p_lo_in = m_lo * coef;

      full     = ({{(PROD_W-PHI_W){p_hi_ff[PHI_W-1]}}, p_hi_ff} <<< FRAC_W)
               + {{(PROD_W-PLO_W){p_lo_ff[PLO_W-1]}}, p_lo_ff};
      rnd_coef = (full + COEF_RND) >>> COEF_FRAC;
      rnd_gain = (full + GAIN_RND) >>> OUT_SHIFT;
      prod_in  = pgain_ff ? rnd_gain[PRODR_W-1:0] : rnd_coef[PRODR_W-1:0];

      w_in   = w_ff;
      acc_in = acc_ff;
      if (load) begin
         acc_in = x_load;
      end else begin
         unique case (ctrl.acc_op)
            ACC_HOLD:       acc_in = acc_ff;
            ACC_ADD_P:      acc_in = acc_ff + prod_ext;
            ACC_SAT_ADD_P:  acc_in = acc_sat_ext + prod_ext;
            ACC_SATW_ADD_P: begin
               acc_in = acc_sat_ext + prod_ext;
               w_in   = acc_sat;
            end
            ACC_ADD_D:      acc_in = acc_ff + dly_ext;
            default:        acc_in = acc_ff;
         endcase
      end

      if (prod_ff[PRODR_W-1:SAMPLE_WIDTH-1]
          == {(PRODR_W-SAMPLE_WIDTH+1){prod_ff[PRODR_W-1]}}) begin
         sample_out = prod_ff[SAMPLE_WIDTH-1:0];
      end else begin
         sample_out = {prod_ff[PRODR_W-1], {(SAMPLE_WIDTH-1){~prod_ff[PRODR_W-1]}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DLY; i++) begin
            dly_ff[i] <= '0;
         end
         pvld_ff <= 1'b0;
      end else begin
         pvld_ff <= ctrl.mul_en;
         if (ctrl.sh_en) begin
            dly_ff[{ctrl.sh_sec, 1'b1}] <= dly_ff[{ctrl.sh_sec, 1'b0}];
            dly_ff[{ctrl.sh_sec, 1'b0}] <= w_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      w_ff   <= w_in;
      if (ctrl.mul_en) begin
         p_hi_ff  <= p_hi_in;
         p_lo_ff  <= p_lo_in;
         pgain_ff <= (ctrl.coef_idx == GAIN_IDX);
      end
      if (pvld_ff) begin
         prod_ff <= prod_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/elliptic_lowpass_biquad_cascade.sv
`timescale 1ns / 1ps
`default_nettype none

// One sample is processed at a time: a 25-step microcode program runs every
// multiply of the four sections and the output gain through one shared multiplier,
// and the next sample is accepted only once the program has finished the last one.
// The result register lets the next sample be accepted while a result waits.
// Reset (synchronous, active high) clears all section delays and the control state.

module elliptic_lowpass_biquad_cascade #(
   parameter int SAMPLE_WIDTH = elbc_pkg::SAMPLE_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_sample_out
);
   import elbc_pkg::*;

   ctrl_type                        ctrl;
   logic                            out_busy;
   logic                            out_load;
   logic                            accept;
   logic signed [SAMPLE_WIDTH-1:0]  dp_sample;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0]  rsp_sample_ff;

   assign out_busy = rsp_valid_ff && !rsp_ready;
   assign accept   = req_valid && req_ready;

   elbc_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .out_busy (out_busy),
      .ctrl     (ctrl),
      .in_ready (req_ready),
      .out_load (out_load)
   );

   elbc_datapath #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .load       (accept),
      .sample_in  (req_sample_in),
      .sample_out (dp_sample)
   );

   assign rsp_valid_in = out_load || out_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_sample_ff <= dp_sample;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

`ifndef SYNTH
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("item accepted while previous item still in progress");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid)
      else $error("result load did not raise rsp_valid");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> !(rsp_valid && !rsp_ready))
      else $error("result register overwritten before item was taken");

   a_ready_not_load: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && out_load))
      else $error("input wait and result load in the same step");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_elliptic_lowpass_biquad_cascade.sv
`timescale 1ns / 1ps

module tb_elliptic_lowpass_biquad_cascade;

   localparam int SW           = elbc_pkg::SAMPLE_WIDTH_DEF;
   localparam int RAND_ITEMS   = 1300;
   localparam int CALM_FROM    = 500;
   localparam int CALM_TO      = 750;
   localparam int HOLD_AT      = 150;
   localparam int HOLD_CYCLES  = 400;
   localparam int PAUSE_AT     = 900;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 60;
   localparam int PRINT_CAP    = 50;

   localparam logic signed [27:0] OUT_GAIN   = 28'sd117378943;
   localparam logic signed [79:0] DLY_MAX    = 80'sh7FFF_FFFF_FFFF;
   localparam logic signed [79:0] DLY_MIN    = -80'sh8000_0000_0000;
   localparam logic signed [79:0] OUT_MAX    = (80'sd1 <<< (SW - 1)) - 1;
   localparam logic signed [79:0] OUT_MIN    = -(80'sd1 <<< (SW - 1));
   localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

   typedef enum logic [1:0] {
      TAP_A1,
      TAP_A2,
      TAP_B1
   } tap_type;

   typedef struct packed {
      logic [SW-1:0] sample;
      logic          has_golden;
      logic [SW-1:0] golden;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic signed [SW-1:0] req_sample_in;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic signed [SW-1:0] rsp_sample_out;

   logic                 offer_has_golden;
   logic signed [SW-1:0] offer_golden;
   logic signed [SW-1:0] predicted;
   logic signed [SW-1:0] wanted;
   logic signed [47:0]   dly_line [8];
   logic signed [SW-1:0] expected_out [$];
   stim_row_type         dir_rows [$];
   logic                 calm_stretch;
   logic                 held;

   int samples_taken = 0;
   int results_seen  = 0;
   int mismatches    = 0;
   int stall_cycles  = 0;
   int burst_left    = 0;

   assign calm_stretch = (samples_taken >= CALM_FROM) && (samples_taken < CALM_TO);

   elliptic_lowpass_biquad_cascade #(
      .SAMPLE_WIDTH(SW)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_sample_out(rsp_sample_out)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic signed [27:0] section_coef(input int sec, input tap_type tap);
      logic signed [27:0] c;
      case (sec * 3 + int'(tap))
         0:       c =  28'sd6770281;
         1:       c = -28'sd3788082;
         2:       c = -28'sd4132511;
         3:       c =  28'sd7041906;
         4:       c = -28'sd3480768;
         5:       c = -28'sd1542724;
         6:       c =  28'sd7298937;
         7:       c = -28'sd3246092;
         8:       c =  28'sd5679806;
         9:       c =  28'sd6687678;
         10:      c = -28'sd4065192;
         11:      c = -28'sd4913130;
         default: c = '0;
      endcase
      return c;
   endfunction

   // Q24 delay times Q6.22 coefficient, back to Q24 with round half up
   function automatic logic signed [79:0] scaled_product(input logic signed [47:0] d,
                                                         input logic signed [27:0] c);
      logic signed [79:0] p;
      p = d * c;
      return (p + 80'sd2097152) >>> 22;
   endfunction

   function automatic logic signed [47:0] clamp48(input logic signed [79:0] v);
      logic signed [47:0] r;
      if (v > DLY_MAX) begin
         r = DLY_MAX[47:0];
      end else if (v < DLY_MIN) begin
         r = DLY_MIN[47:0];
      end else begin
         r = v[47:0];
      end
      return r;
   endfunction

   // advance the four sections by one sample and return the scaled output
   function automatic logic signed [SW-1:0] filter_sample(input logic signed [SW-1:0] s);
      logic signed [79:0] acc;
      logic signed [79:0] q;
      logic signed [47:0] w;
      logic signed [47:0] d1;
      logic signed [47:0] d2;
      acc = 80'(s);
      acc = acc <<< (25 - SW);
      for (int k = 0; k < 4; k++) begin
         d1  = dly_line[2*k];
         d2  = dly_line[2*k+1];
         w   = clamp48(acc + scaled_product(d1, section_coef(k, TAP_A1))
                           + scaled_product(d2, section_coef(k, TAP_A2)));
         acc = clamp48(w + scaled_product(d1, section_coef(k, TAP_B1)) + d2);
         dly_line[2*k+1] = d1;
         dly_line[2*k]   = w;
      end
      q = acc * OUT_GAIN;
      q = (q + (80'sd1 <<< (64 - SW))) >>> (65 - SW);
      if (q > OUT_MAX) begin
         q = OUT_MAX;
      end else if (q < OUT_MIN) begin
         q = OUT_MIN;
      end
      return q[SW-1:0];
   endfunction

   task automatic report_mismatch(input string what, input logic signed [SW-1:0] got,
                                  input logic signed [SW-1:0] want);
      if (mismatches < PRINT_CAP) begin
         $display("result %0d: %s, got %0d, expected %0d", results_seen, what, got, want);
      end
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_out.size() == 0) begin
               report_mismatch("no sample pending", rsp_sample_out, '0);
            end else begin
               wanted = expected_out.pop_front();
               if (rsp_sample_out !== wanted) begin
                  report_mismatch("sample_out differs", rsp_sample_out, wanted);
               end
            end
            results_seen++;
         end
         if (req_valid && req_ready) begin
            predicted = filter_sample(req_sample_in);
            if (offer_has_golden) begin
               predicted = offer_golden;
            end
            expected_out.push_back(predicted);
            samples_taken++;
         end
      end
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("elliptic_lowpass_biquad_cascade test failed");
      $finish;
   end

   initial begin
      rsp_ready = 1'b0;
      held      = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && results_seen >= HOLD_AT) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_ready <= calm_stretch || ($urandom_range(99) >= 11);
         end
      end
   end

   task automatic offer_sample(input logic signed [SW-1:0] s, input logic has,
                               input logic signed [SW-1:0] g);
      int target;
      while (!calm_stretch && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_in    <= s;
      offer_has_golden <= has;
      offer_golden     <= g;
      target = samples_taken + 1;
      do @(negedge clock); while (samples_taken < target);
   endtask

   initial begin
      logic signed [SW-1:0] s;
      logic signed [SW-1:0] prev;
      stim_row_type         row;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample_in    = '0;
      offer_has_golden = 1'b0;
      offer_golden     = '0;
      prev             = '0;
      for (int i = 0; i < 8; i++) begin
         dly_line[i] = '0;
      end

      // zero state: silence stays silent, and a lone full-scale sample passes
      // every section unchanged, leaving only the output gain
      dir_rows.push_back(stim_row_type'{'0, 1'b1, '0});
      dir_rows.push_back(stim_row_type'{SAMPLE_MAX, 1'b1, 16'sd3});
      dir_rows.push_back(stim_row_type'{'0, 1'b0, '0});
      dir_rows.push_back(stim_row_type'{'0, 1'b0, '0});
      dir_rows.push_back(stim_row_type'{SAMPLE_MIN, 1'b0, '0});
      repeat (8) dir_rows.push_back(stim_row_type'{SAMPLE_MAX, 1'b0, '0});
      repeat (2) begin
         dir_rows.push_back(stim_row_type'{SAMPLE_MIN, 1'b0, '0});
         dir_rows.push_back(stim_row_type'{SAMPLE_MAX, 1'b0, '0});
      end
      dir_rows.push_back(stim_row_type'{16'sd1, 1'b0, '0});
      dir_rows.push_back(stim_row_type'{-16'sd1, 1'b0, '0});
      dir_rows.push_back(stim_row_type'{16'h5555, 1'b0, '0});
      dir_rows.push_back(stim_row_type'{16'hAAAA, 1'b0, '0});
      dir_rows.push_back(stim_row_type'{'0, 1'b0, '0});
      dir_rows.push_back(stim_row_type'{SAMPLE_MAX, 1'b0, '0});
      dir_rows.push_back(stim_row_type'{SAMPLE_MIN, 1'b0, '0});

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         offer_sample(row.sample, row.has_golden, row.golden);
      end

      for (int i = 0; i < RAND_ITEMS; i++) begin
         if (i == PAUSE_AT) begin
            req_valid <= 1'b0;
            do @(negedge clock); while (expected_out.size() != 0);
         end
         if (burst_left > 0) begin
            burst_left--;
            s = prev;
         end else begin
            case ($urandom_range(9))
               0, 1, 2, 3: s = SW'($urandom);
               4, 5:       s = SW'(int'($urandom_range(1023)) - 512);
               6: begin
                  s = prev;
                  burst_left = $urandom_range(20, 3);
               end
               7: begin
                  s = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
                  burst_left = $urandom_range(40, 5);
               end
               8:       s = -prev;
               default: s = prev + SW'(int'($urandom_range(255)) - 128);
            endcase
         end
         prev = s;
         offer_sample(s, 1'b0, '0);
      end

      req_valid <= 1'b0;
      do @(negedge clock); while (expected_out.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("elliptic_lowpass_biquad_cascade test passed");
      end else begin
         $display("elliptic_lowpass_biquad_cascade test failed");
      end
      $finish;
   end

endmodule
